// ----- design/setu_pkg.sv -----
// Shared widths, command codes and rule-store control type for the edge transition unit.
package setu_pkg;

  // Default sizing of the stores
  localparam int SITE_COUNT_DEF  = 4096;
  localparam int STATE_COUNT_DEF = 16;
  localparam int MAX_TRANS_DEF   = 8;

  // Fixed field widths of the command and result ports
  localparam int CMD_W    = 3;
  localparam int SITE_W   = 12;
  localparam int STATE_W  = 4;
  localparam int RSLOT_W  = 3;
  localparam int THR_W    = 64;
  localparam int RCNT_W   = 4;
  localparam int TARGET_W = 2 * STATE_W;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_WSITE  = 3'd0,
    CMD_WRULE  = 3'd1,
    CMD_WCOUNT = 3'd2,
    CMD_STEP   = 3'd3,
    CMD_RSITE  = 3'd4
  } cmd_e;

  // Strobes from the sequencer into the rule store
  typedef struct packed {
    logic cnt_we;
    logic cnt_re;
    logic slot_we;
    logic slot_re;
  } rule_ctl_t;

endpackage

// ----- design/stochastic_edge_transition_unit.sv -----
// Top level of the edge transition unit: site store, command sequencer and result register.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+------------------------------
//  command  | cmd_i, site_*_i, pair_*_i, rule_slot_i, | accepted when start && !busy
//           | threshold_i, target_*_i, rule_count_i,  |
//           | roll_i                                  |
//  result   | state_first_o, state_second_o, fired_o, | valid for one cycle on done_o
//           | fired_slot_o                            |
//
// Writes and unknown codes end in ST_MOD with done_o; a read ends in ST_SITE_RD after it.
// A step runs ST_MOD, ST_PAIR, then ST_SCAN until the scan stops at slot k (the hit, else
// count-1, 0 for an empty list), plus ST_WB when a slot fires; one slot is read per cycle.
// After reset the site and count stores are cleared, one entry a cycle, over
// max(SITE_COUNT, STATE_COUNT^2) entries (4096 by default) with busy high.
// busy drops with done_o, so a new item may be accepted at the edge that ends the strobe.
// The receiver cannot stall; busy alone paces the sender.
module stochastic_edge_transition_unit #(
  parameter int SITE_COUNT  = setu_pkg::SITE_COUNT_DEF,
  parameter int STATE_COUNT = setu_pkg::STATE_COUNT_DEF,
  parameter int MAX_TRANS   = setu_pkg::MAX_TRANS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [setu_pkg::CMD_W-1:0]   cmd_i,
  input  logic [setu_pkg::SITE_W-1:0]  site_first_i,
  input  logic [setu_pkg::SITE_W-1:0]  site_second_i,
  input  logic [setu_pkg::STATE_W-1:0] site_value_i,
  input  logic [setu_pkg::STATE_W-1:0] pair_first_i,
  input  logic [setu_pkg::STATE_W-1:0] pair_second_i,
  input  logic [setu_pkg::RSLOT_W-1:0] rule_slot_i,
  input  logic [setu_pkg::THR_W-1:0]   threshold_i,
  input  logic [setu_pkg::STATE_W-1:0] target_first_i,
  input  logic [setu_pkg::STATE_W-1:0] target_second_i,
  input  logic [setu_pkg::RCNT_W-1:0]  rule_count_i,
  input  logic [setu_pkg::THR_W-1:0]   roll_i,
  output logic                         done_o,
  output logic [setu_pkg::STATE_W-1:0] state_first_o,
  output logic [setu_pkg::STATE_W-1:0] state_second_o,
  output logic                         fired_o,
  output logic [setu_pkg::RSLOT_W-1:0] fired_slot_o
);

  localparam int SITE_W     = setu_pkg::SITE_W;
  localparam int STATE_W    = setu_pkg::STATE_W;
  localparam int RSLOT_W    = setu_pkg::RSLOT_W;
  localparam int THR_W      = setu_pkg::THR_W;
  localparam int TARGET_W   = setu_pkg::TARGET_W;
  localparam int SITE_AW    = $clog2(SITE_COUNT);
  localparam int PAIR_DEPTH = STATE_COUNT * STATE_COUNT;
  localparam int SLOT_DEPTH = PAIR_DEPTH * MAX_TRANS;
  localparam int PAIR_AW    = $clog2(PAIR_DEPTH);
  localparam int SLOT_AW    = $clog2(SLOT_DEPTH);
  localparam int CNT_W      = $clog2(MAX_TRANS + 1);
  localparam int CLR_DEPTH  = (SITE_COUNT > PAIR_DEPTH) ? SITE_COUNT : PAIR_DEPTH;
  localparam int CLR_W      = $clog2(CLR_DEPTH);
  localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_DEPTH - 1);

  typedef enum logic [6:0] {
    ST_CLEAR   = 7'b0000001,
    ST_IDLE    = 7'b0000010,
    ST_MOD     = 7'b0000100,
    ST_SITE_RD = 7'b0001000,
    ST_PAIR    = 7'b0010000,
    ST_SCAN    = 7'b0100000,
    ST_WB      = 7'b1000000
  } fsm_e;

  fsm_e state_q, state_d;
  logic [CLR_W-1:0] clr_q, clr_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic             pair_ok_q, pair_ok_d;
  logic [PAIR_AW-1:0] pair_q, pair_d;
  logic             accept;

  // Captured command payload
  setu_pkg::cmd_e         cmd_q;
  logic [SITE_W-1:0]      raw1_q, raw2_q;
  logic [STATE_W-1:0]     value_q, pf_q, ps_q, tf_q, ts_q;
  logic [RSLOT_W-1:0]     slot_q;
  logic [THR_W-1:0]       thr_q, roll_q;
  logic [setu_pkg::RCNT_W-1:0] rcnt_q;

  // Site addresses after the modulo
  logic [SITE_AW-1:0] addr1, addr2;

  // Site memory port
  logic [STATE_W-1:0] site_mem [SITE_COUNT];
  logic               site_we, site_re;
  logic [SITE_AW-1:0] site_wa;
  logic [STATE_W-1:0] site_wd;
  logic [STATE_W-1:0] rd1_q, rd2_q;

  // Rule store port
  setu_pkg::rule_ctl_t   rctl;
  logic [PAIR_AW-1:0]    cnt_addr;
  logic [CNT_W-1:0]      cnt_wdata, cnt_rdata;
  logic [SLOT_AW-1:0]    slot_addr;
  logic [THR_W-1:0]      thr_rdata;
  logic [TARGET_W-1:0]   tgt_rdata;

  // Result register
  logic               done_q, done_d;
  logic [STATE_W-1:0] res_first_q, res_first_d, res_second_q, res_second_d;
  logic               res_fired_q, res_fired_d;
  logic [RSLOT_W-1:0] res_slot_q, res_slot_d;

  // Helper values of the sequencer
  logic               wpair_ok, spair_ok, wslot_ok, hit, more;
  logic [PAIR_AW-1:0] wpair, spair;
  logic [CNT_W-1:0]   count_eff;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  // Reduce site indices modulo SITE_COUNT
  if (SITE_COUNT >= (1 << SITE_W)) begin : g_mod_wide
    assign addr1 = SITE_AW'(raw1_q);
    assign addr2 = SITE_AW'(raw2_q);
  end else begin : g_mod_recip
    localparam int MOD_SH = 24;
    localparam int MUL_W  = SITE_W + MOD_SH + 1;
    localparam longint unsigned RECIP =
      ((longint'(1) << MOD_SH) + longint'(SITE_COUNT) - 1) / longint'(SITE_COUNT);
    logic [MUL_W-1:0]  prod1, prod2;
    logic [SITE_W-1:0] quo1_q, quo2_q;
    logic [SITE_W-1:0] rem1, rem2;

    // Estimate the quotient by reciprocal multiply; exact for 12-bit indices
    assign prod1 = MUL_W'(site_first_i) * MUL_W'(RECIP);
    assign prod2 = MUL_W'(site_second_i) * MUL_W'(RECIP);

    always_ff @(posedge clk_i) begin
      if (accept) begin
        quo1_q <= prod1[MOD_SH +: SITE_W];
        quo2_q <= prod2[MOD_SH +: SITE_W];
      end
    end

    // Subtract quotient times modulus
    assign rem1  = raw1_q - SITE_W'(32'(quo1_q) * SITE_COUNT);
    assign rem2  = raw2_q - SITE_W'(32'(quo2_q) * SITE_COUNT);
    assign addr1 = rem1[SITE_AW-1:0];
    assign addr2 = rem2[SITE_AW-1:0];
  end

  // Capture the item payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= setu_pkg::cmd_e'(cmd_i);
      raw1_q  <= site_first_i;
      raw2_q  <= site_second_i;
      value_q <= site_value_i;
      pf_q    <= pair_first_i;
      ps_q    <= pair_second_i;
      slot_q  <= rule_slot_i;
      thr_q   <= threshold_i;
      tf_q    <= target_first_i;
      ts_q    <= target_second_i;
      rcnt_q  <= rule_count_i;
      roll_q  <= roll_i;
    end
  end

  // Site memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (site_we) begin
      site_mem[site_wa] <= site_wd;
    end
    if (site_re) begin
      rd1_q <= site_mem[addr1];
      rd2_q <= site_mem[addr2];
    end
  end

  setu_rule_store #(
    .STATE_COUNT (STATE_COUNT),
    .MAX_TRANS   (MAX_TRANS)
  ) u_rule_store (
    .clk_i       (clk_i),
    .ctl_i       (rctl),
    .cnt_addr_i  (cnt_addr),
    .cnt_wdata_i (cnt_wdata),
    .cnt_rdata_o (cnt_rdata),
    .slot_addr_i (slot_addr),
    .thr_wdata_i (thr_q),
    .tgt_wdata_i ({ts_q, tf_q}),
    .thr_rdata_o (thr_rdata),
    .tgt_rdata_o (tgt_rdata)
  );

  // Pair index of a rule write and of a step
  assign wpair_ok = (32'(pf_q) < STATE_COUNT) && (32'(ps_q) < STATE_COUNT);
  assign wpair    = wpair_ok ? PAIR_AW'(32'(pf_q) * STATE_COUNT + 32'(ps_q)) : '0;
  assign wslot_ok = (32'(slot_q) < MAX_TRANS);
  assign spair_ok = (32'(rd1_q) < STATE_COUNT) && (32'(rd2_q) < STATE_COUNT);
  assign spair    = spair_ok ? PAIR_AW'(32'(rd1_q) * STATE_COUNT + 32'(rd2_q)) : '0;

  // Slot compare of the scan
  assign count_eff = pair_ok_q ? cnt_rdata : '0;
  assign hit       = (n_q < count_eff) && (thr_rdata > roll_q);
  assign more      = ((CNT_W + 1)'(n_q) + (CNT_W + 1)'(1)) < (CNT_W + 1)'(count_eff);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    n_d          = n_q;
    pair_ok_d    = pair_ok_q;
    pair_d       = pair_q;
    site_we      = 1'b0;
    site_re      = 1'b0;
    site_wa      = addr1;
    site_wd      = '0;
    rctl         = '0;
    cnt_addr     = wpair;
    cnt_wdata    = '0;
    slot_addr    = SLOT_AW'(32'(wpair) * MAX_TRANS + 32'(slot_q));
    done_d       = 1'b0;
    res_first_d  = '0;
    res_second_d = '0;
    res_fired_d  = 1'b0;
    res_slot_d   = '0;

    unique case (state_q)
      // Sweep the site store and the count store to zero after reset
      ST_CLEAR: begin
        site_we      = (32'(clr_q) < SITE_COUNT);
        site_wa      = SITE_AW'(clr_q);
        rctl.cnt_we  = (32'(clr_q) < PAIR_DEPTH);
        cnt_addr     = PAIR_AW'(clr_q);
        clr_d        = clr_q + CLR_W'(1);
        if (clr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          state_d = ST_MOD;
        end
      end

      // Execute writes, issue site reads
      ST_MOD: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
        unique case (cmd_q)
          setu_pkg::CMD_WSITE: begin
            site_we = 1'b1;
            site_wd = value_q;
          end
          setu_pkg::CMD_WRULE: begin
            rctl.slot_we = wpair_ok && wslot_ok;
          end
          setu_pkg::CMD_WCOUNT: begin
            rctl.cnt_we = wpair_ok;
            cnt_wdata   = (32'(rcnt_q) > MAX_TRANS) ? CNT_W'(MAX_TRANS) : CNT_W'(rcnt_q);
          end
          setu_pkg::CMD_STEP: begin
            site_re = 1'b1;
            done_d  = 1'b0;
            state_d = ST_PAIR;
          end
          setu_pkg::CMD_RSITE: begin
            site_re = 1'b1;
            done_d  = 1'b0;
            state_d = ST_SITE_RD;
          end
          default: begin
          end
        endcase
      end

      // Report the site that was read
      ST_SITE_RD: begin
        done_d      = 1'b1;
        res_first_d = rd1_q;
        state_d     = ST_IDLE;
      end

      // Look up the pair count and the first slot
      ST_PAIR: begin
        pair_ok_d    = spair_ok;
        pair_d       = spair;
        rctl.cnt_re  = 1'b1;
        cnt_addr     = spair;
        rctl.slot_re = 1'b1;
        slot_addr    = SLOT_AW'(32'(spair) * MAX_TRANS);
        n_d          = '0;
        state_d      = ST_SCAN;
      end

      // Compare one slot a cycle, prefetch the next
      ST_SCAN: begin
        slot_addr = SLOT_AW'(32'(pair_q) * MAX_TRANS + 32'(n_q) + 1);
        if (hit) begin
          site_we = 1'b1;
          site_wa = addr1;
          site_wd = tgt_rdata[STATE_W-1:0];
          state_d = ST_WB;
        end else if (more) begin
          rctl.slot_re = 1'b1;
          n_d          = n_q + CNT_W'(1);
        end else begin
          done_d       = 1'b1;
          res_first_d  = rd1_q;
          res_second_d = rd2_q;
          state_d      = ST_IDLE;
        end
      end

      // Write the second site; it wins when both indices match
      ST_WB: begin
        site_we      = 1'b1;
        site_wa      = addr2;
        site_wd      = tgt_rdata[TARGET_W-1:STATE_W];
        done_d       = 1'b1;
        res_first_d  = (addr1 == addr2) ? tgt_rdata[TARGET_W-1:STATE_W]
                                        : tgt_rdata[STATE_W-1:0];
        res_second_d = tgt_rdata[TARGET_W-1:STATE_W];
        res_fired_d  = 1'b1;
        res_slot_d   = RSLOT_W'(n_q);
        state_d      = ST_IDLE;
      end

      default: begin
        state_d = ST_CLEAR;
        clr_d   = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      n_q       <= '0;
      pair_ok_q <= 1'b0;
      pair_q    <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      n_q       <= n_d;
      pair_ok_q <= pair_ok_d;
      pair_q    <= pair_d;
      done_q    <= done_d;
    end
  end

  // Hold the result for its strobe cycle
  always_ff @(posedge clk_i) begin
    if (done_d) begin
      res_first_q  <= res_first_d;
      res_second_q <= res_second_d;
      res_fired_q  <= res_fired_d;
      res_slot_q   <= res_slot_d;
    end
  end

  assign done_o         = done_q;
  assign state_first_o  = res_first_q;
  assign state_second_o = res_second_q;
  assign fired_o        = res_fired_q;
  assign fired_slot_o   = res_slot_q;

endmodule

// ----- design/setu_rule_store.sv -----
// Rule store: per-pair slot counts and per-slot thresholds and target states.
module setu_rule_store #(
  parameter int STATE_COUNT = setu_pkg::STATE_COUNT_DEF,
  parameter int MAX_TRANS   = setu_pkg::MAX_TRANS_DEF,
  localparam int PAIR_DEPTH = STATE_COUNT * STATE_COUNT,
  localparam int SLOT_DEPTH = PAIR_DEPTH * MAX_TRANS,
  localparam int PAIR_AW    = $clog2(PAIR_DEPTH),
  localparam int SLOT_AW    = $clog2(SLOT_DEPTH),
  localparam int CNT_W      = $clog2(MAX_TRANS + 1)
) (
  input  logic                          clk_i,
  input  setu_pkg::rule_ctl_t           ctl_i,
  input  logic [PAIR_AW-1:0]            cnt_addr_i,
  input  logic [CNT_W-1:0]              cnt_wdata_i,
  output logic [CNT_W-1:0]              cnt_rdata_o,
  input  logic [SLOT_AW-1:0]            slot_addr_i,
  input  logic [setu_pkg::THR_W-1:0]    thr_wdata_i,
  input  logic [setu_pkg::TARGET_W-1:0] tgt_wdata_i,
  output logic [setu_pkg::THR_W-1:0]    thr_rdata_o,
  output logic [setu_pkg::TARGET_W-1:0] tgt_rdata_o
);

  logic [CNT_W-1:0]              cnt_mem [PAIR_DEPTH];
  logic [setu_pkg::THR_W-1:0]    thr_mem [SLOT_DEPTH];
  logic [setu_pkg::TARGET_W-1:0] tgt_mem [SLOT_DEPTH];

  // Count memory: one port, registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.cnt_we) begin
      cnt_mem[cnt_addr_i] <= cnt_wdata_i;
    end
    if (ctl_i.cnt_re) begin
      cnt_rdata_o <= cnt_mem[cnt_addr_i];
    end
  end

  // Slot memories: one port, registered read, shared address
  always_ff @(posedge clk_i) begin
    if (ctl_i.slot_we) begin
      thr_mem[slot_addr_i] <= thr_wdata_i;
      tgt_mem[slot_addr_i] <= tgt_wdata_i;
    end
    if (ctl_i.slot_re) begin
      thr_rdata_o <= thr_mem[slot_addr_i];
      tgt_rdata_o <= tgt_mem[slot_addr_i];
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the edge transition unit: directed and random command items.
`timescale 1ns / 1ps

module tb_top;

  localparam int CMD_W       = setu_pkg::CMD_W;
  localparam int SITE_W      = setu_pkg::SITE_W;
  localparam int STATE_W     = setu_pkg::STATE_W;
  localparam int RSLOT_W     = setu_pkg::RSLOT_W;
  localparam int THR_W       = setu_pkg::THR_W;
  localparam int RCNT_W      = setu_pkg::RCNT_W;
  localparam int TARGET_W    = setu_pkg::TARGET_W;
  localparam int SITE_COUNT  = setu_pkg::SITE_COUNT_DEF;
  localparam int STATE_COUNT = setu_pkg::STATE_COUNT_DEF;
  localparam int MAX_TRANS   = setu_pkg::MAX_TRANS_DEF;

  // Codes that the block must treat as no-ops
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

  localparam int SLOT_DEPTH   = STATE_COUNT * STATE_COUNT * MAX_TRANS;
  localparam int RANDOM_ITEMS = 1300;
  localparam int DRAIN_LIMIT  = 10000;
  localparam int TAIL_CYCLES  = 20;
  localparam logic [THR_W-1:0] THR_MAX = '1;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [SITE_W-1:0]  site_first;
    logic [SITE_W-1:0]  site_second;
    logic [STATE_W-1:0] site_value;
    logic [STATE_W-1:0] pair_first;
    logic [STATE_W-1:0] pair_second;
    logic [RSLOT_W-1:0] rule_slot;
    logic [THR_W-1:0]   threshold;
    logic [STATE_W-1:0] target_first;
    logic [STATE_W-1:0] target_second;
    logic [RCNT_W-1:0]  rule_count;
    logic [THR_W-1:0]   roll;
  } cmd_item_t;

  typedef struct {
    logic [STATE_W-1:0] state_first;
    logic [STATE_W-1:0] state_second;
    logic               fired;
    logic [RSLOT_W-1:0] fired_slot;
  } outcome_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [CMD_W-1:0]   cmd_i;
  logic [SITE_W-1:0]  site_first_i;
  logic [SITE_W-1:0]  site_second_i;
  logic [STATE_W-1:0] site_value_i;
  logic [STATE_W-1:0] pair_first_i;
  logic [STATE_W-1:0] pair_second_i;
  logic [RSLOT_W-1:0] rule_slot_i;
  logic [THR_W-1:0]   threshold_i;
  logic [STATE_W-1:0] target_first_i;
  logic [STATE_W-1:0] target_second_i;
  logic [RCNT_W-1:0]  rule_count_i;
  logic [THR_W-1:0]   roll_i;
  logic               done_o;
  logic [STATE_W-1:0] state_first_o;
  logic [STATE_W-1:0] state_second_o;
  logic               fired_o;
  logic [RSLOT_W-1:0] fired_slot_o;

  // Shadow copy of the lattice and the rule table
  logic [STATE_W-1:0]  site_mem  [SITE_COUNT];
  logic [RCNT_W-1:0]   count_mem [STATE_COUNT * STATE_COUNT];
  logic [THR_W-1:0]    thr_mem   [SLOT_DEPTH];
  logic [TARGET_W-1:0] tgt_mem   [SLOT_DEPTH];
  bit                  slot_written [SLOT_DEPTH];

  outcome_t pending_outcomes[$];
  int       err_count = 0;

  stochastic_edge_transition_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .site_first_i   (site_first_i),
    .site_second_i  (site_second_i),
    .site_value_i   (site_value_i),
    .pair_first_i   (pair_first_i),
    .pair_second_i  (pair_second_i),
    .rule_slot_i    (rule_slot_i),
    .threshold_i    (threshold_i),
    .target_first_i (target_first_i),
    .target_second_i(target_second_i),
    .rule_count_i   (rule_count_i),
    .roll_i         (roll_i),
    .done_o         (done_o),
    .state_first_o  (state_first_o),
    .state_second_o (state_second_o),
    .fired_o        (fired_o),
    .fired_slot_o   (fired_slot_o)
  );

  always #5 clk_i = ~clk_i;

  // Print one error line and count it
  task automatic flag_error(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic int slot_addr(input logic [STATE_W-1:0] a, input logic [STATE_W-1:0] b,
                                   input int n);
    return (int'(a) * STATE_COUNT + int'(b)) * MAX_TRANS + n;
  endfunction

  // Number of slots of a pair written without a hole from slot zero
  function automatic int written_prefix(input logic [STATE_W-1:0] a,
                                        input logic [STATE_W-1:0] b);
    int n;
    n = 0;
    while (n < MAX_TRANS && slot_written[slot_addr(a, b, n)]) n++;
    return n;
  endfunction

  // Apply one item to the shadow lattice and return the result it yields
  function automatic outcome_t predict_outcome(input cmd_item_t it);
    outcome_t            r;
    int                  cnt;
    int                  a;
    int                  n;
    logic [TARGET_W-1:0] tgt;
    r = '{default: '0};
    case (it.cmd)
      setu_pkg::CMD_WSITE: begin
        site_mem[it.site_first] = it.site_value;
      end
      setu_pkg::CMD_WRULE: begin
        a = slot_addr(it.pair_first, it.pair_second, int'(it.rule_slot));
        thr_mem[a] = it.threshold;
        tgt_mem[a] = {it.target_second, it.target_first};
        slot_written[a] = 1'b1;
      end
      setu_pkg::CMD_WCOUNT: begin
        count_mem[int'(it.pair_first) * STATE_COUNT + int'(it.pair_second)] =
          (it.rule_count > MAX_TRANS) ? RCNT_W'(MAX_TRANS) : it.rule_count;
      end
      setu_pkg::CMD_STEP: begin
        cnt = int'(count_mem[int'(site_mem[it.site_first]) * STATE_COUNT +
                             int'(site_mem[it.site_second])]);
        // Scan slots in order and fire the first one above the roll
        for (n = 0; n < cnt && !r.fired; n++) begin
          a = slot_addr(site_mem[it.site_first], site_mem[it.site_second], n);
          if (thr_mem[a] > it.roll) begin
            tgt = tgt_mem[a];
            site_mem[it.site_first]  = tgt[STATE_W-1:0];
            site_mem[it.site_second] = tgt[TARGET_W-1:STATE_W];
            r.fired      = 1'b1;
            r.fired_slot = RSLOT_W'(n);
          end
        end
        r.state_first  = site_mem[it.site_first];
        r.state_second = site_mem[it.site_second];
      end
      setu_pkg::CMD_RSITE: begin
        r.state_first = site_mem[it.site_first];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic cmd_item_t blank_item(input logic [CMD_W-1:0] code);
    cmd_item_t it;
    it = '{default: '0};
    it.cmd = code;
    return it;
  endfunction

  // Drive one item, hold it until accepted, then queue its prediction
  task automatic send_item(input cmd_item_t it);
    @(negedge clk_i);
    cmd_i           = it.cmd;
    site_first_i    = it.site_first;
    site_second_i   = it.site_second;
    site_value_i    = it.site_value;
    pair_first_i    = it.pair_first;
    pair_second_i   = it.pair_second;
    rule_slot_i     = it.rule_slot;
    threshold_i     = it.threshold;
    target_first_i  = it.target_first;
    target_second_i = it.target_second;
    rule_count_i    = it.rule_count;
    roll_i          = it.roll;
    start           = 1'b1;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    pending_outcomes.push_back(predict_outcome(it));
  endtask

  // Drop start for a number of cycles
  task automatic idle_cycles(input int n);
    if (n > 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // Compare each result with the oldest prediction
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && done_o) begin
      if (pending_outcomes.size() == 0) begin
        flag_error("result strobe with no item pending");
      end else begin
        want = pending_outcomes.pop_front();
        if (state_first_o !== want.state_first)
          flag_error($sformatf("state_first got %0h want %0h", state_first_o,
                               want.state_first));
        if (state_second_o !== want.state_second)
          flag_error($sformatf("state_second got %0h want %0h", state_second_o,
                               want.state_second));
        if (fired_o !== want.fired)
          flag_error($sformatf("fired got %0b want %0b", fired_o, want.fired));
        if (fired_slot_o !== want.fired_slot)
          flag_error($sformatf("fired_slot got %0d want %0d", fired_slot_o,
                               want.fired_slot));
      end
    end
  end

  task automatic test_reset_state();
    cmd_item_t it;
    it = blank_item(setu_pkg::CMD_RSITE);
    send_item(it);
    it.site_first = '1;
    send_item(it);
  endtask

  task automatic test_site_access();
    cmd_item_t it;
    it = blank_item(setu_pkg::CMD_WSITE);
    it.site_first = '1;
    it.site_value = '1;
    send_item(it);
    it = blank_item(setu_pkg::CMD_RSITE);
    it.site_first = '1;
    send_item(it);
  endtask

  // Spare codes with every field at ones must change nothing
  task automatic test_unknown_codes();
    cmd_item_t it;
    it = '{default: '1};
    it.cmd = CMD_SPARE_A;
    send_item(it);
    it.cmd = CMD_SPARE_B;
    send_item(it);
    it.cmd = CMD_SPARE_C;
    send_item(it);
  endtask

  // Pair with no rules: step reports the sites unchanged
  task automatic test_empty_pair();
    cmd_item_t it;
    it = blank_item(setu_pkg::CMD_STEP);
    it.site_second = 12'd1;
    it.roll = {$urandom, $urandom};
    send_item(it);
  endtask

  // Zero threshold never fires, so the scan moves on to the next slot
  task automatic test_rule_scan();
    cmd_item_t it;
    it = blank_item(setu_pkg::CMD_WRULE);
    it.pair_first    = 4'd15;
    it.target_first  = 4'd1;
    it.target_second = 4'd2;
    send_item(it);
    it.rule_slot     = 3'd1;
    it.threshold     = THR_MAX;
    it.target_first  = 4'hA;
    it.target_second = 4'h5;
    send_item(it);
    it = blank_item(setu_pkg::CMD_WCOUNT);
    it.pair_first = 4'd15;
    it.rule_count = 4'd2;
    send_item(it);
    it = blank_item(setu_pkg::CMD_WSITE);
    it.site_first = 12'd5;
    send_item(it);
    it = blank_item(setu_pkg::CMD_STEP);
    it.site_first  = '1;
    it.site_second = 12'd5;
    send_item(it);
    it = blank_item(setu_pkg::CMD_RSITE);
    it.site_first = 12'd5;
    send_item(it);
  endtask

  // Full rule list, oversized count, and one site named twice
  task automatic test_saturation();
    cmd_item_t it;
    it = blank_item(setu_pkg::CMD_WRULE);
    it.pair_first  = 4'd15;
    it.pair_second = 4'd15;
    for (int s = 0; s < MAX_TRANS; s++) begin
      it.rule_slot     = RSLOT_W'(s);
      it.threshold     = (s == MAX_TRANS - 1) ? THR_MAX : '0;
      it.target_first  = 4'h3;
      it.target_second = 4'hC;
      send_item(it);
    end
    it = blank_item(setu_pkg::CMD_WCOUNT);
    it.pair_first  = 4'd15;
    it.pair_second = 4'd15;
    it.rule_count  = '1;
    send_item(it);
    it = blank_item(setu_pkg::CMD_WSITE);
    it.site_first = '1;
    it.site_value = 4'd15;
    send_item(it);
    it = blank_item(setu_pkg::CMD_STEP);
    it.site_first  = '1;
    it.site_second = '1;
    it.roll        = THR_MAX - 1;
    send_item(it);
  endtask

  // Mostly a small hot set of sites and states, so rule lists fill and steps fire
  function automatic logic [SITE_W-1:0] pick_site();
    if ($urandom_range(0, 99) < 75) return SITE_W'($urandom_range(0, 15));
    return SITE_W'($urandom);
  endfunction

  function automatic logic [STATE_W-1:0] pick_state();
    if ($urandom_range(0, 99) < 80) return STATE_W'($urandom_range(0, 3));
    return STATE_W'($urandom);
  endfunction

  function automatic logic [THR_W-1:0] pick_wide();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return THR_MAX;
    return {$urandom, $urandom};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic test_random_traffic();
    cmd_item_t it;
    int        sent;
    int        burst;
    int        r;
    int        p;
    sent  = 0;
    burst = 0;
    while (sent < RANDOM_ITEMS) begin
      // Fill every field, then set the ones the command uses
      it.site_first    = SITE_W'($urandom);
      it.site_second   = SITE_W'($urandom);
      it.site_value    = STATE_W'($urandom);
      it.pair_first    = STATE_W'($urandom);
      it.pair_second   = STATE_W'($urandom);
      it.rule_slot     = RSLOT_W'($urandom);
      it.threshold     = {$urandom, $urandom};
      it.target_first  = STATE_W'($urandom);
      it.target_second = STATE_W'($urandom);
      it.rule_count    = RCNT_W'($urandom);
      it.roll          = {$urandom, $urandom};
      r = $urandom_range(0, 99);
      if (r < 45) begin
        it.cmd         = setu_pkg::CMD_STEP;
        it.site_first  = pick_site();
        it.site_second = ($urandom_range(0, 99) < 15) ? it.site_first : pick_site();
        it.roll        = pick_wide();
      end else if (r < 60) begin
        it.cmd        = setu_pkg::CMD_WSITE;
        it.site_first = pick_site();
        it.site_value = pick_state();
      end else if (r < 80) begin
        it.cmd           = setu_pkg::CMD_WRULE;
        it.pair_first    = pick_state();
        it.pair_second   = pick_state();
        p = written_prefix(it.pair_first, it.pair_second);
        if (p < MAX_TRANS && $urandom_range(0, 99) < 75) it.rule_slot = RSLOT_W'(p);
        it.threshold     = pick_wide();
        it.target_first  = pick_state();
        it.target_second = pick_state();
      end else if (r < 90) begin
        it.cmd         = setu_pkg::CMD_WCOUNT;
        it.pair_first  = pick_state();
        it.pair_second = pick_state();
        // Never enable a slot that has not been written
        p = written_prefix(it.pair_first, it.pair_second);
        if (p < MAX_TRANS) it.rule_count = RCNT_W'($urandom_range(0, p));
      end else if (r < 97) begin
        it.cmd        = setu_pkg::CMD_RSITE;
        it.site_first = pick_site();
      end else begin
        case ($urandom_range(0, 2))
          0:       it.cmd = CMD_SPARE_A;
          1:       it.cmd = CMD_SPARE_B;
          default: it.cmd = CMD_SPARE_C;
        endcase
      end
      send_item(it);
      if (it.cmd <= setu_pkg::CMD_RSITE) sent++;
      // Alternate idle traffic with back-to-back bursts
      if (burst > 0) begin
        burst--;
      end else if ($urandom_range(0, 199) == 0) begin
        burst = $urandom_range(30, 60);
      end else begin
        idle_cycles(pick_gap());
      end
    end
    @(negedge clk_i);
    start = 1'b0;
  endtask

  initial begin
    int guard;
    foreach (site_mem[i]) site_mem[i] = '0;
    foreach (count_mem[i]) count_mem[i] = '0;
    foreach (thr_mem[i]) thr_mem[i] = '0;
    foreach (tgt_mem[i]) tgt_mem[i] = '0;
    rst_ni          = 1'b0;
    start           = 1'b0;
    cmd_i           = '0;
    site_first_i    = '0;
    site_second_i   = '0;
    site_value_i    = '0;
    pair_first_i    = '0;
    pair_second_i   = '0;
    rule_slot_i     = '0;
    threshold_i     = '0;
    target_first_i  = '0;
    target_second_i = '0;
    rule_count_i    = '0;
    roll_i          = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_site_access();
    test_unknown_codes();
    test_empty_pair();
    test_rule_scan();
    test_saturation();
    test_random_traffic();

    // Drain outstanding results, then let the pipeline settle
    guard = 0;
    while (pending_outcomes.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    if (pending_outcomes.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_outcomes.size()));
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/setu_pkg.sv
design/setu_rule_store.sv
design/stochastic_edge_transition_unit.sv
tb/tb_top.sv
